@@ rtl/cdos_pkg.sv @@
// Package for the centroid distance outlier split block.
// Holds sizes, payload structs and the sequencer state type.
// No dependencies.
package cdos_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int COORD_W    = 24;
  localparam int THR_W      = 12;
  localparam logic [THR_W-1:0] THR_RESET = 12'd768;

  // sum of coordinates or distances over a full set
  localparam int SUM_W   = COORD_W + ADDR_W;
  // one square of a 25-bit difference
  localparam int PROD_W  = 2 * COORD_W;
  // sum of three squares
  localparam int ACC_W   = PROD_W + 2;
  // sum of squared deviations over a full set
  localparam int VSUM_W  = PROD_W + ADDR_W;
  localparam int DIV_W   = VSUM_W;
  localparam int SQRT_W  = VSUM_W;
  localparam int ROOT_W  = SQRT_W / 2;
  localparam int BOUND_W = THR_W + COORD_W;
  localparam logic [COORD_W-1:0] DIST_MAX = {COORD_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      is_inlier;
    logic                      overflowed;
    logic                      last_result;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_CDIV_GO,
    ST_CDIV_WAIT,
    ST_DIST_RD,
    ST_DIST_MUL,
    ST_DIST_ACC,
    ST_DIST_SQ_GO,
    ST_DIST_SQ_WAIT,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_VAR_RD,
    ST_VAR_MUL,
    ST_VAR_ACC,
    ST_VDIV_GO,
    ST_VDIV_WAIT,
    ST_SD_GO,
    ST_SD_WAIT,
    ST_BOUND,
    ST_EMIT_RD,
    ST_EMIT_CMP,
    ST_EMIT_OUT
  } state_e;

endpackage

@@ rtl/cdos_div.sv @@
// Iterative unsigned divider, one quotient bit per cycle (restoring).
// Divides a DIV_W-bit dividend by the CNT_W-bit point count.
// Depends on cdos_pkg.
module cdos_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cdos_pkg::DIV_W-1:0] dividend_i,
  input  logic [cdos_pkg::CNT_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [cdos_pkg::DIV_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(cdos_pkg::DIV_W + 1);

  logic                       busy_q;
  logic [STEP_W-1:0]          step_q;
  logic [cdos_pkg::DIV_W-1:0] quo_q;
  logic [cdos_pkg::CNT_W-1:0] rem_q;
  logic [cdos_pkg::CNT_W:0]   trial;
  logic [cdos_pkg::CNT_W:0]   diff;
  logic                       ge;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[cdos_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  assign done_o     = busy_q && (step_q == '0);
  assign quotient_o = quo_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(cdos_pkg::DIV_W);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  // datapath; quotient holds after done until the next start
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q && (step_q != '0)) begin
      rem_q <= ge ? diff[cdos_pkg::CNT_W-1:0] : trial[cdos_pkg::CNT_W-1:0];
      quo_q <= {quo_q[cdos_pkg::DIV_W-2:0], ge};
    end
  end

endmodule

@@ rtl/cdos_sqrt.sv @@
// Iterative integer square root, one root bit per cycle (floor).
// Radicand SQRT_W bits, root ROOT_W bits.
// Depends on cdos_pkg.
module cdos_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cdos_pkg::SQRT_W-1:0] radicand_i,
  output logic                        done_o,
  output logic [cdos_pkg::ROOT_W-1:0] root_o
);

  localparam int STEP_W = $clog2(cdos_pkg::ROOT_W + 1);
  localparam int REM_W  = cdos_pkg::ROOT_W + 2;

  logic                        busy_q;
  logic [STEP_W-1:0]           step_q;
  logic [cdos_pkg::SQRT_W-1:0] rad_q;
  logic [cdos_pkg::ROOT_W-1:0] root_q;
  logic [REM_W-1:0]            rem_q;
  logic [REM_W+1:0]            shifted;
  logic [REM_W+1:0]            trial;
  logic [REM_W+1:0]            diff;
  logic                        ge;

  // bring down two radicand bits, try root*4+1
  assign shifted = {rem_q, rad_q[cdos_pkg::SQRT_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign diff    = shifted - trial;
  assign ge      = shifted >= trial;

  assign done_o = busy_q && (step_q == '0);
  assign root_o = root_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(cdos_pkg::ROOT_W);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q && (step_q != '0)) begin
      rem_q  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      root_q <= {root_q[cdos_pkg::ROOT_W-2:0], ge};
      rad_q  <= {rad_q[cdos_pkg::SQRT_W-3:0], 2'b00};
    end
  end

endmodule

@@ rtl/centroid_distance_outlier_split.sv @@
// Centroid distance outlier split, top level.
// Depends on cdos_pkg, cdos_div and cdos_sqrt.
//
// Usage:
//   Points enter on the in channel (valid/ready), one request per cycle while
//   the block is loading. Up to MAX_POINTS points are kept in a point memory;
//   further points are dropped and flag the set as overflowed. The request
//   with last_point set closes the set (even if it was dropped itself).
//   The block then runs over the memory: a sum pass, three centroid divides,
//   a distance pass (three squares and a root per point, distances go to a
//   second memory), a mean divide, a variance pass, a divide and a root for
//   the standard deviation, and an emit pass that sends every stored point
//   in load order with its inlier flag on the out channel.
//   Run time is set by the bit-serial divider and the bit-serial root unit,
//   which runs once per point in the distance pass and once for the deviation.
//   The input is not ready from the closing request until the last result of
//   the set has been taken. A stalled receiver simply holds the emit pass.
//   Reset empties the set and loads the threshold with 3.0; the memories are
//   not cleared. The threshold may be written only while the block is idle.
module centroid_distance_outlier_split (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cdos_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output cdos_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [cdos_pkg::THR_W-1:0]      cfg_wdata_i
);

  localparam int CW = cdos_pkg::COORD_W;
  localparam int PW = 3 * CW;

  cdos_pkg::state_e state_q, state_d;

  // control registers
  logic [cdos_pkg::CNT_W-1:0]  count_q;
  logic                        ovf_q;
  logic [cdos_pkg::CNT_W-1:0]  idx_q;
  logic [1:0]                  axis_q;
  logic                        out_valid_q;
  logic [cdos_pkg::THR_W-1:0]  thr_q;

  // datapath registers
  logic signed [cdos_pkg::SUM_W-1:0] sum_q [3];
  logic signed [CW-1:0]              cen_q [3];
  logic [cdos_pkg::PROD_W-1:0]       prod_q;
  logic [cdos_pkg::ACC_W-1:0]        acc_q;
  logic [cdos_pkg::SUM_W-1:0]        dsum_q;
  logic [cdos_pkg::VSUM_W-1:0]       vsum_q;
  logic [CW-1:0]                     mean_q;
  logic [CW-1:0]                     sd_q;
  logic [cdos_pkg::BOUND_W-1:0]      bound_q;
  cdos_pkg::out_item_t               out_q;

  // memories
  logic [PW-1:0] pt_mem   [cdos_pkg::MAX_POINTS];
  logic [CW-1:0] dist_mem [cdos_pkg::MAX_POINTS];
  logic [PW-1:0] pt_rd_q;
  logic [CW-1:0] dist_rd_q;

  // control outputs of the sequencer
  logic in_ready, pt_re, dist_re, div_start, sqrt_start;
  logic [cdos_pkg::DIV_W-1:0]  div_dividend;
  logic [cdos_pkg::SQRT_W-1:0] sqrt_radicand;

  logic                        div_done, sqrt_done;
  logic [cdos_pkg::DIV_W-1:0]  div_quo;
  logic [cdos_pkg::ROOT_W-1:0] sqrt_root;

  logic                        in_fire, out_fire, pt_we, dist_we, last_idx;
  logic signed [CW-1:0]        rd_c [3];
  logic signed [CW:0]          dk;
  logic signed [2*CW+1:0]      dk_sq;
  logic signed [CW:0]          dd;
  logic signed [2*CW+1:0]      dd_sq;
  logic [CW-1:0]               ad;
  logic [cdos_pkg::SUM_W-1:0]  sum_abs;
  logic                        sum_neg;
  logic [CW-1:0]               cen_mag;
  logic [CW-1:0]               dist_val;
  logic                        inlier;

  assign in_fire  = in_valid_i && in_ready;
  assign out_fire = out_valid_q && out_ready_i;
  assign last_idx = cdos_pkg::CNT_W'(idx_q + 1'b1) == count_q;
  assign pt_we    = in_fire && (count_q < cdos_pkg::CNT_W'(cdos_pkg::MAX_POINTS));
  assign dist_we  = (state_q == cdos_pkg::ST_DIST_SQ_WAIT) && sqrt_done;

  // unpack the point read from memory
  assign rd_c[0] = pt_rd_q[3*CW-1 -: CW];
  assign rd_c[1] = pt_rd_q[2*CW-1 -: CW];
  assign rd_c[2] = pt_rd_q[CW-1:0];

  // one square per cycle: coordinate minus centroid
  assign dk    = {rd_c[axis_q][CW-1], rd_c[axis_q]} - {cen_q[axis_q][CW-1], cen_q[axis_q]};
  assign dk_sq = dk * dk;

  // deviation of a distance from the mean
  assign dd    = $signed({1'b0, dist_rd_q}) - $signed({1'b0, mean_q});
  assign dd_sq = dd * dd;
  assign ad    = dd[CW] ? CW'(-dd) : dd[CW-1:0];
  assign inlier = cdos_pkg::BOUND_W'({ad, 8'd0}) < bound_q;

  // signed centroid divide via magnitude
  assign sum_neg = sum_q[axis_q][cdos_pkg::SUM_W-1];
  assign sum_abs = sum_neg ? cdos_pkg::SUM_W'(-sum_q[axis_q])
                           : cdos_pkg::SUM_W'(sum_q[axis_q]);
  assign cen_mag = div_quo[CW-1:0];

  // distance saturates to the store width
  assign dist_val = (sqrt_root > cdos_pkg::ROOT_W'(cdos_pkg::DIST_MAX))
                    ? cdos_pkg::DIST_MAX : sqrt_root[CW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cdos_pkg::ST_LOAD:      if (in_fire && in_data_i.last_point) state_d = cdos_pkg::ST_SUM_RD;
      cdos_pkg::ST_SUM_RD:    state_d = cdos_pkg::ST_SUM_ACC;
      cdos_pkg::ST_SUM_ACC:   state_d = last_idx ? cdos_pkg::ST_CDIV_GO : cdos_pkg::ST_SUM_RD;
      cdos_pkg::ST_CDIV_GO:   state_d = cdos_pkg::ST_CDIV_WAIT;
      cdos_pkg::ST_CDIV_WAIT: if (div_done) begin
        state_d = (axis_q == 2'd2) ? cdos_pkg::ST_DIST_RD : cdos_pkg::ST_CDIV_GO;
      end
      cdos_pkg::ST_DIST_RD:   state_d = cdos_pkg::ST_DIST_MUL;
      cdos_pkg::ST_DIST_MUL:  if (axis_q == 2'd2) state_d = cdos_pkg::ST_DIST_ACC;
      cdos_pkg::ST_DIST_ACC:  state_d = cdos_pkg::ST_DIST_SQ_GO;
      cdos_pkg::ST_DIST_SQ_GO: state_d = cdos_pkg::ST_DIST_SQ_WAIT;
      cdos_pkg::ST_DIST_SQ_WAIT: if (sqrt_done) begin
        state_d = last_idx ? cdos_pkg::ST_MEAN_GO : cdos_pkg::ST_DIST_RD;
      end
      cdos_pkg::ST_MEAN_GO:   state_d = cdos_pkg::ST_MEAN_WAIT;
      cdos_pkg::ST_MEAN_WAIT: if (div_done) state_d = cdos_pkg::ST_VAR_RD;
      cdos_pkg::ST_VAR_RD:    state_d = cdos_pkg::ST_VAR_MUL;
      cdos_pkg::ST_VAR_MUL:   state_d = cdos_pkg::ST_VAR_ACC;
      cdos_pkg::ST_VAR_ACC:   state_d = last_idx ? cdos_pkg::ST_VDIV_GO : cdos_pkg::ST_VAR_RD;
      cdos_pkg::ST_VDIV_GO:   state_d = cdos_pkg::ST_VDIV_WAIT;
      cdos_pkg::ST_VDIV_WAIT: if (div_done) state_d = cdos_pkg::ST_SD_GO;
      cdos_pkg::ST_SD_GO:     state_d = cdos_pkg::ST_SD_WAIT;
      cdos_pkg::ST_SD_WAIT:   if (sqrt_done) state_d = cdos_pkg::ST_BOUND;
      cdos_pkg::ST_BOUND:     state_d = cdos_pkg::ST_EMIT_RD;
      cdos_pkg::ST_EMIT_RD:   state_d = cdos_pkg::ST_EMIT_CMP;
      cdos_pkg::ST_EMIT_CMP:  state_d = cdos_pkg::ST_EMIT_OUT;
      cdos_pkg::ST_EMIT_OUT:  if (out_fire) begin
        state_d = last_idx ? cdos_pkg::ST_LOAD : cdos_pkg::ST_EMIT_RD;
      end
      default:                state_d = cdos_pkg::ST_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready      = 1'b0;
    pt_re         = 1'b0;
    dist_re       = 1'b0;
    div_start     = 1'b0;
    sqrt_start    = 1'b0;
    div_dividend  = cdos_pkg::DIV_W'(sum_abs);
    sqrt_radicand = cdos_pkg::SQRT_W'(acc_q);
    case (state_q)
      cdos_pkg::ST_LOAD:       in_ready = 1'b1;
      cdos_pkg::ST_SUM_RD:     pt_re = 1'b1;
      cdos_pkg::ST_CDIV_GO:    div_start = 1'b1;
      cdos_pkg::ST_DIST_RD:    pt_re = 1'b1;
      cdos_pkg::ST_DIST_SQ_GO: sqrt_start = 1'b1;
      cdos_pkg::ST_MEAN_GO: begin
        div_start    = 1'b1;
        div_dividend = cdos_pkg::DIV_W'(dsum_q);
      end
      cdos_pkg::ST_VAR_RD:     dist_re = 1'b1;
      cdos_pkg::ST_VDIV_GO: begin
        div_start    = 1'b1;
        div_dividend = cdos_pkg::DIV_W'(vsum_q);
      end
      cdos_pkg::ST_SD_GO: begin
        sqrt_start    = 1'b1;
        sqrt_radicand = cdos_pkg::SQRT_W'(div_quo);
      end
      cdos_pkg::ST_EMIT_RD: begin
        pt_re   = 1'b1;
        dist_re = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdos_pkg::ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= cdos_pkg::THR_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (pt_we) begin
        count_q <= count_q + 1'b1;
      end else if (in_fire) begin
        ovf_q <= 1'b1;
      end
      case (state_q)
        cdos_pkg::ST_SUM_ACC,
        cdos_pkg::ST_VAR_ACC: idx_q <= last_idx ? '0 : idx_q + 1'b1;
        cdos_pkg::ST_DIST_SQ_WAIT: if (sqrt_done) begin
          idx_q <= last_idx ? '0 : idx_q + 1'b1;
        end
        cdos_pkg::ST_CDIV_WAIT: if (div_done) begin
          axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 1'b1;
        end
        cdos_pkg::ST_DIST_MUL: axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 1'b1;
        cdos_pkg::ST_EMIT_CMP: out_valid_q <= 1'b1;
        cdos_pkg::ST_EMIT_OUT: if (out_fire) begin
          out_valid_q <= 1'b0;
          if (last_idx) begin
            idx_q   <= '0;
            count_q <= '0;
            ovf_q   <= 1'b0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      cdos_pkg::ST_LOAD: begin
        for (int a = 0; a < 3; a++) begin
          sum_q[a] <= '0;
        end
        dsum_q <= '0;
        vsum_q <= '0;
      end
      cdos_pkg::ST_SUM_ACC: begin
        for (int a = 0; a < 3; a++) begin
          sum_q[a] <= sum_q[a] + cdos_pkg::SUM_W'(rd_c[a]);
        end
      end
      cdos_pkg::ST_CDIV_WAIT: if (div_done) begin
        cen_q[axis_q] <= sum_neg ? CW'(-cen_mag) : cen_mag;
      end
      cdos_pkg::ST_DIST_RD: begin
        prod_q <= '0;
        acc_q  <= '0;
      end
      cdos_pkg::ST_DIST_MUL: begin
        prod_q <= dk_sq[cdos_pkg::PROD_W-1:0];
        acc_q  <= acc_q + cdos_pkg::ACC_W'(prod_q);
      end
      cdos_pkg::ST_DIST_ACC: acc_q <= acc_q + cdos_pkg::ACC_W'(prod_q);
      cdos_pkg::ST_DIST_SQ_WAIT: if (sqrt_done) begin
        dsum_q <= dsum_q + cdos_pkg::SUM_W'(dist_val);
      end
      cdos_pkg::ST_MEAN_WAIT: if (div_done) begin
        mean_q <= div_quo[CW-1:0];
      end
      cdos_pkg::ST_VAR_MUL: prod_q <= dd_sq[cdos_pkg::PROD_W-1:0];
      cdos_pkg::ST_VAR_ACC: vsum_q <= vsum_q + cdos_pkg::VSUM_W'(prod_q);
      cdos_pkg::ST_SD_WAIT: if (sqrt_done) begin
        sd_q <= sqrt_root[CW-1:0];
      end
      cdos_pkg::ST_BOUND: bound_q <= cdos_pkg::BOUND_W'(thr_q) * cdos_pkg::BOUND_W'(sd_q);
      cdos_pkg::ST_EMIT_CMP: begin
        out_q.out_x       <= rd_c[0];
        out_q.out_y       <= rd_c[1];
        out_q.out_z       <= rd_c[2];
        out_q.is_inlier   <= inlier;
        out_q.overflowed  <= ovf_q;
        out_q.last_result <= last_idx;
      end
      default: ;
    endcase
  end

  // point memory: written at load, read by the sum, distance and emit passes
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[count_q[cdos_pkg::ADDR_W-1:0]] <=
        {in_data_i.point_x, in_data_i.point_y, in_data_i.point_z};
    end
    if (pt_re) begin
      pt_rd_q <= pt_mem[idx_q[cdos_pkg::ADDR_W-1:0]];
    end
  end

  // distance memory
  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[idx_q[cdos_pkg::ADDR_W-1:0]] <= dist_val;
    end
    if (dist_re) begin
      dist_rd_q <= dist_mem[idx_q[cdos_pkg::ADDR_W-1:0]];
    end
  end

  cdos_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  cdos_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sqrt_radicand),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/cdos_checker.sv @@
// Port-level checks for centroid_distance_outlier_split, bound to the top.
// Depends on cdos_pkg.
module cdos_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input cdos_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cdos_pkg::out_item_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // loading and emitting never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is shown");

  // closing request stops the load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_point |=> !in_ready_o)
    else $error("input still ready after closing request");

  // set stays busy until its last result is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_result |=> !in_ready_o)
    else $error("input ready in the middle of a set");

endmodule

bind centroid_distance_outlier_split cdos_checker u_cdos_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ tb/testbench.sv @@
// Testbench for centroid_distance_outlier_split: point sets in, flagged points out.
// Depends on cdos_pkg and the top level; predicts each set's results and checks them.
module testbench;

  localparam int MAX_CYCLES = 2000000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  cdos_pkg::in_item_t            in_data_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  cdos_pkg::out_item_t           out_data_o;
  logic                          cfg_we_i;
  logic [cdos_pkg::THR_W-1:0]    cfg_wdata_i;

  centroid_distance_outlier_split i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // predictor state
  logic signed [cdos_pkg::COORD_W-1:0] px [cdos_pkg::MAX_POINTS];
  logic signed [cdos_pkg::COORD_W-1:0] py [cdos_pkg::MAX_POINTS];
  logic signed [cdos_pkg::COORD_W-1:0] pz [cdos_pkg::MAX_POINTS];
  int unsigned                 set_count;
  bit                          set_dropped;
  logic [cdos_pkg::THR_W-1:0]  threshold;

  cdos_pkg::in_item_t  pending_points[$];
  cdos_pkg::out_item_t expected_points[$];
  int        mismatches;
  int        cycle_count;
  bit        hold_sender;
  bit        steady_phase;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // absorb one accepted point; on the closing point, predict the whole set
  task automatic predict_point(input cdos_pkg::in_item_t it);
    longint sx, sy, sz, cx, cy, cz, dx, dy, dz, dev;
    longint unsigned sq, dst, dsum, vsum, mean, sd, bound, ad;
    longint unsigned pred_dist [cdos_pkg::MAX_POINTS];
    cdos_pkg::out_item_t o;
    int n;
    sx = 0; sy = 0; sz = 0; dsum = 0; vsum = 0;
    if (set_count < cdos_pkg::MAX_POINTS) begin
      px[set_count] = it.point_x;
      py[set_count] = it.point_y;
      pz[set_count] = it.point_z;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!it.last_point) return;
    n = set_count;
    for (int i = 0; i < n; i++) begin
      sx += px[i]; sy += py[i]; sz += pz[i];
    end
    cx = sx / n; cy = sy / n; cz = sz / n;
    for (int i = 0; i < n; i++) begin
      dx = px[i] - cx; dy = py[i] - cy; dz = pz[i] - cz;
      sq = dx * dx + dy * dy + dz * dz;
      dst = int_sqrt(sq);
      if (dst > 64'hFFFFFF) dst = 64'hFFFFFF;
      pred_dist[i] = dst;
      dsum += dst;
    end
    mean = dsum / n;
    for (int i = 0; i < n; i++) begin
      dev = longint'(pred_dist[i]) - longint'(mean);
      vsum += dev * dev;
    end
    sd = int_sqrt(vsum / n);
    bound = threshold * sd;
    for (int i = 0; i < n; i++) begin
      dev = longint'(pred_dist[i]) - longint'(mean);
      ad = (dev < 0) ? -dev : dev;
      o.out_x = px[i];
      o.out_y = py[i];
      o.out_z = pz[i];
      o.is_inlier = (ad * 256 < bound);
      o.overflowed = set_dropped;
      o.last_result = (i == n - 1);
      expected_points.insert(expected_points.size(), o);
    end
    set_count = 0;
    set_dropped = 1'b0;
  endtask

  function automatic logic signed [cdos_pkg::COORD_W-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 3) == 0 ? 24'sh7FFFFF : 24'sh800000;
      1: return cdos_pkg::COORD_W'($signed($urandom_range(0, 8191)) - 4096);
      default: return cdos_pkg::COORD_W'($urandom);
    endcase
  endfunction

  function automatic cdos_pkg::in_item_t make_point(int mode, bit last);
    cdos_pkg::in_item_t it;
    it.point_x = rand_coord(mode);
    it.point_y = rand_coord(mode);
    it.point_z = rand_coord(mode);
    it.last_point = last;
    return it;
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) predict_point(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_points.size() != 0 && !hold_sender &&
            (steady_phase || $urandom_range(0, 99) >= 20)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_points.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady_phase || $urandom_range(0, 99) >= 20;
      if (out_valid_o && out_ready_i) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          cdos_pkg::out_item_t e;
          e = expected_points.pop_front();
          if (out_data_o !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", e, out_data_o);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_points.size() != 0 || in_valid_i || expected_points.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [cdos_pkg::THR_W-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    threshold   = v;
    cfg_we_i    <= 1'b0;
  endtask

  task automatic queue_set(int n, int mode);
    for (int i = 0; i < n; i++)
      pending_points.insert(pending_points.size(), make_point(mode, i == n - 1));
  endtask

  int sent;

  initial begin
    in_valid_i = 1'b0; in_data_i = '0; out_ready_i = 1'b0;
    cfg_we_i = 1'b0; cfg_wdata_i = '0;
    threshold = cdos_pkg::THR_RESET;
    set_count = 0; set_dropped = 0; mismatches = 0; cycle_count = 0;
    hold_sender = 0; steady_phase = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single point, extremes, mixed magnitudes
    queue_set(1, 1);
    queue_set(3, 0);
    queue_set(2, 2);
    begin
      cdos_pkg::in_item_t a;
      a = make_point(1, 0); pending_points.insert(pending_points.size(), a);
      a.point_x = 24'sh7FFFFF; a.point_y = 24'sh800000; a.point_z = '0;
      pending_points.insert(pending_points.size(), a);
      a = make_point(1, 1); a.point_x = 24'sh000000;
      pending_points.insert(pending_points.size(), a);
    end
    queue_set(6, 1);
    // zero threshold
    write_threshold('0);
    queue_set(5, 1);
    // maximum threshold
    write_threshold({cdos_pkg::THR_W{1'b1}});
    queue_set(5, 2);
    // overflow: full set plus dropped points, closing point dropped too;
    // no idling on either side through this long stretch
    write_threshold(12'd256);
    steady_phase = 1;
    for (int i = 0; i < cdos_pkg::MAX_POINTS + 3; i++)
      pending_points.insert(pending_points.size(),
                            make_point(1, i == cdos_pkg::MAX_POINTS + 2));
    // hold the next set back until every result so far has come back
    while (pending_points.size() != 0) @(posedge clk_i);
    hold_sender = 1;
    queue_set(4, 2);
    while (in_valid_i || expected_points.size() != 0) @(posedge clk_i);
    hold_sender = 0;
    steady_phase = 0;

    // random sets, threshold changed between some sets
    sent = 0;
    while (sent < 16) begin
      int n;
      if ($urandom_range(0, 3) == 0) write_threshold(cdos_pkg::THR_W'($urandom));
      n = $urandom_range(2, 8);
      queue_set(n, $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 1) ? 1 : 2));
      sent += n;
      while (pending_points.size() > 8) @(posedge clk_i);
    end
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_points.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
